// ===== rtl/sliding_window_distinct_max_macros.svh =====
// ----------------------------------------------------------------------------
// Sliding window distinct count - assertion macros
// Concurrent check wrappers; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef SLIDING_WINDOW_DISTINCT_MAX_MACROS_SVH
`define SLIDING_WINDOW_DISTINCT_MAX_MACROS_SVH

`ifndef SYNTHESIS
// Check a property at every clock edge outside reset.
`define SWDM_ASSERT(lbl, ck, rn, prop, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) prop) else $error(msg);
// Check that cons holds at the clock after the one where ante holds.
`define SWDM_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) else $error(msg);
`else
`define SWDM_ASSERT(lbl, ck, rn, prop, msg)
`define SWDM_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg)
`endif

`endif

// ===== rtl/swdm_pkg.sv =====
// ----------------------------------------------------------------------------
// Sliding window distinct count - package
// Field widths, beat types and register codes shared by the block.
// ----------------------------------------------------------------------------
package swdm_pkg;

  localparam int KEY_BITS  = 10;
  localparam int KEY_SPACE = 1 << KEY_BITS;
  localparam int WLEN_W    = 9;   // window_len register field
  localparam int DIST_W    = 9;   // window_distinct / best_distinct fields
  localparam int CFG_AW    = 3;   // byte address, one word per register

  // Register index, taken from the word address bit
  localparam logic REG_WINDOW_LEN = 1'b0;

  typedef struct packed {
    logic [KEY_BITS-1:0] key_value;
    logic                seq_last;
  } swdm_in_t;

  typedef struct packed {
    logic [DIST_W-1:0] window_distinct;
    logic              window_full;
    logic [DIST_W-1:0] best_distinct;
    logic              seq_done;
  } swdm_out_t;

endpackage

// ===== rtl/swdm_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read (read-first).
// ----------------------------------------------------------------------------
module swdm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/swdm_cell.sv =====
// ----------------------------------------------------------------------------
// Sliding window distinct count - window cell
// Holds one key; on a shift takes the new key (tail cell) or its neighbor's.
// ----------------------------------------------------------------------------
module swdm_cell import swdm_pkg::*; (
  input  logic                clk,
  input  logic                shift_en,
  input  logic                load,
  input  logic [KEY_BITS-1:0] key_new,
  input  logic [KEY_BITS-1:0] key_right,
  output logic [KEY_BITS-1:0] key_q
);

  logic [KEY_BITS-1:0] key_r;
  logic [KEY_BITS-1:0] key_nxt;

  always_comb begin
    key_nxt = key_r;
    if (shift_en) begin
      key_nxt = load ? key_new : key_right;
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
  end

  assign key_q = key_r;

endmodule

// ===== rtl/sliding_window_distinct_max.sv =====
// ----------------------------------------------------------------------------
// Sliding window distinct count with best-window tracking
// Counts distinct keys over the last window_len keys and keeps the maximum.
// ----------------------------------------------------------------------------
// Each accepted key produces one result beat: the distinct count of the
// window after this key, a window-full flag, the best distinct count over
// all full windows so far (0 until the window first fills) and an echo of
// seq_last. The window is a row of WINDOW_MAX cells: a new key is loaded
// into cell window_len-1 and every cell hands its key one place down per
// key, so cell 0 always holds the key about to leave the window. Per-key
// occurrence counts live in a 2^KEY_BITS entry RAM. Each key makes one
// read-modify-write of the count RAM for the leaving key, then one for the
// entering key, since the RAM has a single write port. The next key can be
// accepted during the entering step of the previous one when the result
// beat is taken promptly and the previous key was not marked seq_last; a
// held result beat stalls the entering-key step until it is taken. After
// reset the block sweeps all 2^KEY_BITS entries (1024 by default) of the
// count RAM to zero with in_stall high. After a key marked seq_last, and
// after a window_len write, the block shifts the whole row of WINDOW_MAX
// cells (256 by default) past cell 0, zeroing each key's count, before the
// next key is taken. window_len 0 acts as 1, values above WINDOW_MAX as
// WINDOW_MAX; the register reads back as written. Write it only when idle.
// ----------------------------------------------------------------------------
`include "sliding_window_distinct_max_macros.svh"

module sliding_window_distinct_max import swdm_pkg::*; #(
  parameter int WINDOW_MAX = 256
) (
  input  logic              clk,
  input  logic              rst_n,
  // key beats
  input  logic              in_valid,
  output logic              in_stall,
  input  swdm_in_t          in_data,
  // result beats
  output logic              out_valid,
  input  logic              out_stall,
  output swdm_out_t         out_data,
  // register port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  localparam int LEN_W = $clog2(WINDOW_MAX + 1);  // length, fill, counts
  localparam int DRN_W = $clog2(WINDOW_MAX);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LEAVE,   // read-modify-write of the leaving key's count
    ST_ENTER,   // read-modify-write of the entering key's count
    ST_SWEEP,   // zero the whole count RAM after reset
    ST_DRAIN    // shift the row out, zeroing each key's count
  } state_t;

  // Control state
  state_t              state_r, state_nxt;
  logic [WLEN_W-1:0]   wlen_r, wlen_nxt;
  logic [LEN_W-1:0]    len_r, len_nxt;
  logic [LEN_W-1:0]    fill_r, fill_nxt;
  logic [LEN_W-1:0]    distinct_r, distinct_nxt;
  logic [LEN_W-1:0]    best_r, best_nxt;
  logic [KEY_BITS-1:0] sweep_cnt_r, sweep_cnt_nxt;
  logic [DRN_W-1:0]    drain_cnt_r, drain_cnt_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic                wr_en_q;

  // Payload
  swdm_out_t           out_r, out_nxt;
  logic [KEY_BITS-1:0] key_r, old_r;
  logic                last_r;
  logic [KEY_BITS-1:0] rd_addr_q, wr_addr_q;
  logic [LEN_W-1:0]    wr_data_q;

  // Count RAM port
  logic                ram_we;
  logic [KEY_BITS-1:0] ram_wa, ram_ra;
  logic [LEN_W-1:0]    ram_wd, ram_rdata;

  logic                cfg_write, cfg_hit;
  logic [LEN_W-1:0]    len_cfg;
  logic [LEN_W-1:0]    len_m1;
  logic                in_accept;
  logic                p2_hold;
  logic [LEN_W-1:0]    cnt_rd;
  logic                leave_en;
  logic [LEN_W-1:0]    enter_cnt, enter_dist, enter_fill, enter_best;
  logic                enter_full;
  logic                shift_en;

  logic [KEY_BITS-1:0] cell_key [WINDOW_MAX];
  logic [KEY_BITS-1:0] head;

  // ---------------------------------------------------------------------
  // Register port
  // ---------------------------------------------------------------------
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;
  assign cfg_hit   = cfg_write && (paddr[CFG_AW-1] == REG_WINDOW_LEN);
  assign prdata    = (paddr[CFG_AW-1] == REG_WINDOW_LEN) ? 32'(wlen_r) : '0;

  // Clamp the written length to 1..WINDOW_MAX
  always_comb begin
    if (pwdata[WLEN_W-1:0] == '0) begin
      len_cfg = LEN_W'(1);
    end else if (32'(pwdata[WLEN_W-1:0]) > 32'(WINDOW_MAX)) begin
      len_cfg = LEN_W'(WINDOW_MAX);
    end else begin
      len_cfg = LEN_W'(pwdata[WLEN_W-1:0]);
    end
  end

  // ---------------------------------------------------------------------
  // Window row: the new key loads at cell len-1, cell 0 holds the oldest
  // ---------------------------------------------------------------------
  assign len_m1   = len_r - LEN_W'(1);
  assign shift_en = in_accept || (state_r == ST_DRAIN);
  assign head     = cell_key[0];

  for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
    logic [KEY_BITS-1:0] right_key;
    logic                load;

    if (i == WINDOW_MAX - 1) begin : g_top
      assign right_key = in_data.key_value;
    end else begin : g_mid
      assign right_key = cell_key[i+1];
    end

    // Load only on a key beat; a drain shifts every cell down
    assign load = in_accept && (len_m1 == LEN_W'(i));

    swdm_cell u_cell (
      .clk      (clk),
      .shift_en (shift_en),
      .load     (load),
      .key_new  (in_data.key_value),
      .key_right(right_key),
      .key_q    (cell_key[i])
    );
  end

  // ---------------------------------------------------------------------
  // Count RAM, with bypass of a write made at the same edge as the read
  // ---------------------------------------------------------------------
  swdm_ram #(
    .WIDTH(LEN_W),
    .DEPTH(KEY_SPACE)
  ) u_counts (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_wa),
    .wdata(ram_wd),
    .raddr(ram_ra),
    .rdata(ram_rdata)
  );

  assign cnt_rd = (wr_en_q && (wr_addr_q == rd_addr_q)) ? wr_data_q : ram_rdata;

  // ---------------------------------------------------------------------
  // Handshakes
  // ---------------------------------------------------------------------
  // Hold the entering step while the previous result beat waits
  assign p2_hold   = out_valid_r && out_stall;
  assign in_stall  = cfg_write ||
                     !((state_r == ST_IDLE) ||
                       ((state_r == ST_ENTER) && !p2_hold && !last_r));
  assign in_accept = in_valid && !in_stall;

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // ---------------------------------------------------------------------
  // Entering-key arithmetic
  // ---------------------------------------------------------------------
  assign leave_en   = (fill_r >= len_r);
  assign enter_cnt  = (cnt_rd == '1) ? cnt_rd : cnt_rd + LEN_W'(1);
  assign enter_dist = distinct_r + {{(LEN_W-1){1'b0}}, (cnt_rd == '0)};
  assign enter_fill = (fill_r < len_r) ? fill_r + LEN_W'(1) : fill_r;
  assign enter_full = (enter_fill >= len_r);
  assign enter_best = (enter_full && (enter_dist > best_r)) ? enter_dist : best_r;

  // ---------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------
  always_comb begin
    state_nxt     = state_r;
    wlen_nxt      = wlen_r;
    len_nxt       = len_r;
    fill_nxt      = fill_r;
    distinct_nxt  = distinct_r;
    best_nxt      = best_r;
    sweep_cnt_nxt = sweep_cnt_r;
    drain_cnt_nxt = drain_cnt_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_nxt       = out_r;
    ram_we        = 1'b0;
    ram_wa        = head;
    ram_wd        = '0;
    ram_ra        = head;

    case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          state_nxt = ST_LEAVE;
        end
      end

      ST_LEAVE: begin
        ram_ra = key_r;
        // Drop the leaving key; count zero means it is already absent
        if (leave_en && (cnt_rd != '0)) begin
          ram_we = 1'b1;
          ram_wa = old_r;
          ram_wd = cnt_rd - LEN_W'(1);
          if ((cnt_rd == LEN_W'(1)) && (distinct_r != '0)) begin
            distinct_nxt = distinct_r - LEN_W'(1);
          end
        end
        state_nxt = ST_ENTER;
      end

      ST_ENTER: begin
        ram_ra = p2_hold ? key_r : head;
        if (!p2_hold) begin
          ram_we        = 1'b1;
          ram_wa        = key_r;
          ram_wd        = enter_cnt;
          distinct_nxt  = enter_dist;
          fill_nxt      = enter_fill;
          best_nxt      = enter_best;
          out_valid_nxt = 1'b1;
          out_nxt.window_distinct = DIST_W'(enter_dist);
          out_nxt.window_full     = enter_full;
          out_nxt.best_distinct   = DIST_W'(enter_best);
          out_nxt.seq_done        = last_r;
          if (last_r) begin
            // End of sequence: clear totals, then drain the row
            fill_nxt      = '0;
            distinct_nxt  = '0;
            best_nxt      = '0;
            drain_cnt_nxt = '0;
            state_nxt     = ST_DRAIN;
          end else if (in_accept) begin
            state_nxt = ST_LEAVE;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end

      ST_SWEEP: begin
        ram_we        = 1'b1;
        ram_wa        = sweep_cnt_r;
        sweep_cnt_nxt = sweep_cnt_r + KEY_BITS'(1);
        if (sweep_cnt_r == '1) begin
          state_nxt = ST_IDLE;
        end
      end

      ST_DRAIN: begin
        ram_we        = 1'b1;
        ram_wa        = head;
        drain_cnt_nxt = drain_cnt_r + DRN_W'(1);
        if (drain_cnt_r == DRN_W'(WINDOW_MAX - 1)) begin
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // A length write starts a fresh sequence
    if (cfg_hit) begin
      wlen_nxt     = pwdata[WLEN_W-1:0];
      len_nxt      = len_cfg;
      fill_nxt     = '0;
      distinct_nxt = '0;
      best_nxt     = '0;
      if ((state_r != ST_SWEEP) && (state_r != ST_DRAIN)) begin
        drain_cnt_nxt = '0;
        state_nxt     = ST_DRAIN;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_SWEEP;
      wlen_r      <= WLEN_W'(1);
      len_r       <= LEN_W'(1);
      fill_r      <= '0;
      distinct_r  <= '0;
      best_r      <= '0;
      sweep_cnt_r <= '0;
      drain_cnt_r <= '0;
      out_valid_r <= 1'b0;
      out_r       <= '0;
      wr_en_q     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wlen_r      <= wlen_nxt;
      len_r       <= len_nxt;
      fill_r      <= fill_nxt;
      distinct_r  <= distinct_nxt;
      best_r      <= best_nxt;
      sweep_cnt_r <= sweep_cnt_nxt;
      drain_cnt_r <= drain_cnt_nxt;
      out_valid_r <= out_valid_nxt;
      out_r       <= out_nxt;
      wr_en_q     <= ram_we;
    end
  end

  always_ff @(posedge clk) begin
    rd_addr_q <= ram_ra;
    wr_addr_q <= ram_wa;
    wr_data_q <= ram_wd;
    if (in_accept) begin
      key_r  <= in_data.key_value;
      last_r <= in_data.seq_last;
      old_r  <= head;
    end
  end

  // ---------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------
  `SWDM_ASSERT(a_result_from_enter, clk, rst_n,
    $rose(out_valid_r) |-> $past(state_r == ST_ENTER),
    "result beat raised outside the entering step")
  `SWDM_ASSERT(a_distinct_within_fill, clk, rst_n,
    distinct_r <= fill_r,
    "distinct total exceeds keys in window")
  `SWDM_ASSERT(a_best_covers_full, clk, rst_n,
    (fill_r >= len_r) |-> (best_r >= distinct_r),
    "best total below distinct total of a full window")
  `SWDM_ASSERT_NEXT(a_leave_then_enter, clk, rst_n,
    state_r == ST_LEAVE, state_r == ST_ENTER,
    "leaving step not followed by entering step")

endmodule
